>>> rtl/im2col_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared constants, register codes and the queue entry type of the 2-D
// im2col gather block.
// ----------------------------------------------------------------------------
package im2col_pkg;

  localparam int CHANNELS      = 4;
  localparam int MAX_HEIGHT    = 32;
  localparam int MAX_WIDTH     = 32;
  localparam int DILATION_ROWS = 1;
  localparam int DILATION_COLS = 1;

  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 4096;
  localparam int DIM_W       = 6;
  localparam int KIDX_W      = 5;
  localparam int SMALL_W     = 4;
  localparam int KERNEL_MAX  = 32;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam int MAX_DIM = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
  localparam int MAX_DIL = (DILATION_ROWS > DILATION_COLS) ? DILATION_ROWS : DILATION_COLS;
  localparam int POS_W   = $clog2(MAX_DIM + 45 + MAX_DIL * (KERNEL_MAX - 1) + 2);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd7;

  typedef struct packed {
    logic              is_load;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              pad;
    logic              last;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/im2col_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module im2col_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/im2col_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_fifo
// Short job queue between the walk front end and the store back end.
// ----------------------------------------------------------------------------
module im2col_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire im2col_pkg::job_t   push_job,
  output logic                    full,
  input  wire logic               pop,
  output im2col_pkg::job_t        head_job,
  output logic                    empty
);

  import im2col_pkg::*;

  job_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full     = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/im2col_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_front
// Holds the registers and the matrix walk; turns an accepted load into a store
// write job and an emit, until the walk ends, into a gather job with its address and padding flag.
// ----------------------------------------------------------------------------
module im2col_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [im2col_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic [0:0]                          s_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                     push,
  output im2col_pkg::job_t                         push_job,
  input  wire logic                                full
);

  import im2col_pkg::*;

  logic [DIM_W-1:0]   h, w, kh, kw;
  logic [SMALL_W-1:0] ph, pw, sh, sw;

  logic [POS_W-1:0]  rbase, roff, cbase, coff;
  logic [KIDX_W-1:0] kr, kc;
  logic [CH_W-1:0]   ch;
  logic [ADDR_W-1:0] chan_base;
  logic              done;

  logic [POS_W-1:0]  rbase_next, roff_next, cbase_next, coff_next;
  logic [KIDX_W-1:0] kr_next, kc_next;
  logic [CH_W-1:0]   ch_next;
  logic [ADDR_W-1:0] chan_base_next;
  logic              done_next;
  logic              last;

  logic [POS_W-1:0]     span_r, span_c, padded_r, padded_c, lim_r, lim_c;
  logic [POS_W-1:0]     row_sum, col_sum, row_pos, col_pos, rstep, cstep;
  logic                 empty_mx, pad_flag;
  logic [2*DIM_W-1:0]   hw_full, rw_full;
  logic [ADDR_W-1:0]    addr;
  logic                 cmd, accept, emit_go;
  logic [SMALL_W-1:0]   cfg_small;

  assign cmd       = s_tuser[0];
  assign s_tready  = !full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_small = cfg_data[SMALL_W-1:0];

  always_comb begin
    span_r   = POS_W'(DILATION_ROWS) * (POS_W'(kh) - POS_W'(1)) + POS_W'(1);
    span_c   = POS_W'(DILATION_COLS) * (POS_W'(kw) - POS_W'(1)) + POS_W'(1);
    padded_r = POS_W'(h) + (POS_W'(ph) << 1);
    padded_c = POS_W'(w) + (POS_W'(pw) << 1);
    empty_mx = (padded_r < span_r) || (padded_c < span_c);
    lim_r    = padded_r - span_r;
    lim_c    = padded_c - span_c;
    row_sum  = rbase + roff;
    col_sum  = cbase + coff;
    row_pos  = row_sum - POS_W'(ph);
    col_pos  = col_sum - POS_W'(pw);
    pad_flag = (row_sum < POS_W'(ph)) || (row_pos >= POS_W'(h))
            || (col_sum < POS_W'(pw)) || (col_pos >= POS_W'(w));
    hw_full  = (2*DIM_W)'(h) * (2*DIM_W)'(w);
    rw_full  = (2*DIM_W)'(row_pos[DIM_W-1:0]) * (2*DIM_W)'(w);
    addr     = chan_base + ADDR_W'(rw_full) + ADDR_W'(col_pos[DIM_W-1:0]);
    rstep    = rbase + POS_W'(sh);
    cstep    = cbase + POS_W'(sw);
  end

  always_comb begin
    rbase_next     = rbase;
    roff_next      = roff;
    cbase_next     = cbase;
    coff_next      = coff;
    kr_next        = kr;
    kc_next        = kc;
    ch_next        = ch;
    chan_base_next = chan_base;
    done_next      = done;
    last           = 1'b0;
    if (cstep > lim_c) begin
      cbase_next = '0;
      if (rstep > lim_r) begin
        rbase_next = '0;
        if ((DIM_W'(kc) + DIM_W'(1)) >= kw) begin
          kc_next   = '0;
          coff_next = '0;
          if ((DIM_W'(kr) + DIM_W'(1)) >= kh) begin
            kr_next   = '0;
            roff_next = '0;
            if (ch == CH_W'(CHANNELS - 1)) begin
              ch_next        = '0;
              chan_base_next = '0;
              last           = 1'b1;
              done_next      = 1'b1;
            end else begin
              ch_next        = ch + CH_W'(1);
              chan_base_next = chan_base + ADDR_W'(hw_full);
            end
          end else begin
            kr_next   = kr + KIDX_W'(1);
            roff_next = roff + POS_W'(DILATION_ROWS);
          end
        end else begin
          kc_next   = kc + KIDX_W'(1);
          coff_next = coff + POS_W'(DILATION_COLS);
        end
      end else begin
        rbase_next = rstep;
      end
    end else begin
      cbase_next = cstep;
    end
  end

  assign emit_go = accept && (cmd == CMD_EMIT) && !done && !empty_mx;
  assign push    = (accept && (cmd == CMD_LOAD)) || emit_go;

  always_comb begin
    push_job.is_load = (cmd == CMD_LOAD);
    push_job.addr    = (cmd == CMD_LOAD) ? s_tdata[ADDR_W-1:0] : addr;
    push_job.data    = s_tdata[ADDR_W +: WORD_W];
    push_job.pad     = pad_flag;
    push_job.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h         <= DIM_W'(32);
      w         <= DIM_W'(32);
      kh        <= DIM_W'(3);
      kw        <= DIM_W'(3);
      ph        <= SMALL_W'(1);
      pw        <= SMALL_W'(1);
      sh        <= SMALL_W'(1);
      sw        <= SMALL_W'(1);
      rbase     <= '0;
      roff      <= '0;
      cbase     <= '0;
      coff      <= '0;
      kr        <= '0;
      kc        <= '0;
      ch        <= '0;
      chan_base <= '0;
      done      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT: begin
          h <= (cfg_data == '0) ? DIM_W'(1) :
               (int'(cfg_data) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_data;
        end
        REG_IMAGE_WIDTH: begin
          w <= (cfg_data == '0) ? DIM_W'(1) :
               (int'(cfg_data) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_data;
        end
        REG_KERNEL_HEIGHT: begin
          kh <= (cfg_data == '0) ? DIM_W'(1) :
                (int'(cfg_data) > KERNEL_MAX) ? DIM_W'(KERNEL_MAX) : cfg_data;
        end
        REG_KERNEL_WIDTH: begin
          kw <= (cfg_data == '0) ? DIM_W'(1) :
                (int'(cfg_data) > KERNEL_MAX) ? DIM_W'(KERNEL_MAX) : cfg_data;
        end
        REG_PAD_ROWS:    ph <= cfg_small;
        REG_PAD_COLS:    pw <= cfg_small;
        REG_STRIDE_ROWS: sh <= (cfg_small == '0) ? SMALL_W'(1) : cfg_small;
        REG_STRIDE_COLS: sw <= (cfg_small == '0) ? SMALL_W'(1) : cfg_small;
        default: begin
        end
      endcase
      rbase     <= '0;
      roff      <= '0;
      cbase     <= '0;
      coff      <= '0;
      kr        <= '0;
      kc        <= '0;
      ch        <= '0;
      chan_base <= '0;
      done      <= 1'b0;
    end else if (emit_go) begin
      rbase     <= rbase_next;
      roff      <= roff_next;
      cbase     <= cbase_next;
      coff      <= coff_next;
      kr        <= kr_next;
      kc        <= kc_next;
      ch        <= ch_next;
      chan_base <= chan_base_next;
      done      <= done_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/im2col_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_back
// Executes queued jobs in order: writes image words into the store, reads
// gathered words and drives the result channel through an output register.
// ----------------------------------------------------------------------------
module im2col_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire im2col_pkg::job_t                  head_job,
  input  wire logic                              empty,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [im2col_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [0:0]                             m_tuser,
  output logic                                   m_tlast
);

  import im2col_pkg::*;

  logic              s1_valid, s1_pad, s1_last, s1_move;
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] rdata;

  assign s1_move = s1_valid && (!m_tvalid || m_tready);
  assign pop     = !empty && (head_job.is_load || !s1_valid || s1_move);
  assign ram_we  = pop && head_job.is_load;
  assign ram_re  = pop && !head_job.is_load;

  im2col_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_job.addr),
    .wdata (head_job.data),
    .re    (ram_re),
    .raddr (head_job.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pad  <= head_job.pad;
      s1_last <= head_job.last;
    end
    if (s1_move) begin
      m_tdata    <= s1_pad ? '0 : rdata;
      m_tuser[0] <= s1_pad;
      m_tlast    <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ram_re) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/im2col_2d_gather_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_2d_gather_top
// 2-D im2col gather with padding, stride and dilation over a 4096-word
// image store.
//
//   channel  direction  contents
//   s_*      in         command (tuser), load_address + pixel_word (tdata)
//   m_*      out        column_value (tdata), padding flag (tuser), last (tlast)
//   cfg_*    in         register write: index 0..7, data up to 6 bits
//
// One item per cycle sustained for loads and gathers alike while the result
// channel is ready. A gather result passes the queue slot, the store read and
// the output register in turn. Reset clears the walk and the queue; the store
// is not cleared. A stalled result channel fills the four-entry queue before
// s_tready drops.
// ----------------------------------------------------------------------------
module im2col_2d_gather_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [11:0] load_address, [43:12] pixel_word, [47:44] zero
  input  wire logic [im2col_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] command
  input  wire logic [0:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [31:0] column_value
  output logic [im2col_pkg::M_TDATA_W-1:0]         m_tdata,
  // [0] padding flag
  output logic [0:0]                               m_tuser,
  output logic                                     m_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import im2col_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head_job;

  im2col_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  im2col_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  im2col_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
